[rtl/skgc_pkg.sv]
package skgc_pkg;

  localparam int BANDS = 3;

  localparam int SAMPLE_W = 16;
  localparam int BAND_W   = 2;
  localparam int LVL_W    = 17;
  localparam int RATIO_W  = 13;
  localparam int KNEE_W   = 12;
  localparam int MASTER_W = 14;
  localparam int BANK_W   = 48;
  localparam int ENA_W    = 3;
  localparam int IDX_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_RATIO,
    REG_KNEE,
    REG_MASTER,
    REG_THRESH,
    REG_MAKEUP,
    REG_ENABLE
  } cfg_reg_t;

  localparam logic [RATIO_W-1:0]  RATIO_RST  = 13'd1024;
  localparam logic [RATIO_W-1:0]  RATIO_MIN  = 13'd256;
  localparam logic [BANK_W-1:0]   THRESH_RST = 48'hF000_EE00_EC00;

  // Log unit: one squaring per stage, plus normalize, scale and round stages.
  localparam int SQ_STEPS = 16;
  localparam int LOG_LAT  = SQ_STEPS + 3;
  localparam logic [18:0] DB_PER_OCT = 19'd394566;

  localparam logic signed [LVL_W-1:0] ZERO_DB = -17'sd40960;
  localparam logic signed [LVL_W-1:0] OUT_MIN = -17'sd48640;
  localparam logic signed [LVL_W-1:0] OUT_MAX = 17'sd15360;
  localparam logic signed [29:0] SAT_LO = -30'sd48640;
  localparam logic signed [29:0] SAT_HI = 30'sd15360;

  localparam int W_W = 23;
  localparam logic [W_W-1:0] KNEE_BASE = 23'd3930;

  // Divider: quotient, dividend and divisor widths.
  localparam int QW = 24;
  localparam int NW = 60;
  localparam int DW = 37;

  localparam int LAT = LOG_LAT + 3 + QW + 2;

  typedef enum logic [1:0] {
    RG_BELOW,
    RG_KNEE,
    RG_ABOVE
  } region_t;

  typedef struct packed {
    logic              vld;
    logic [BAND_W-1:0] band;
  } log_tag_t;

  typedef struct packed {
    logic                     vld;
    logic signed [LVL_W-1:0]  lvl;
    logic                     bypass;
    region_t                  region;
    logic signed [25:0]       base;
    logic signed [17:0]       offs;
  } cv_tag_t;

  function automatic logic signed [LVL_W-1:0] sat_out(input logic signed [29:0] v);
    logic signed [LVL_W-1:0] r;
    if (v < SAT_LO) begin
      r = OUT_MIN;
    end else if (v > SAT_HI) begin
      r = OUT_MAX;
    end else begin
      r = v[LVL_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/soft_knee_gain_computer.sv]
// Channel   Ports                                          Handshake
// request   start, sample, band                            start && !busy
// result    done, input_level_db, output_level_db          done strobe, one cycle
// config    cfg_valid, cfg_index, cfg_data                 cfg_valid && cfg_ready
//
// One request per cycle is taken. A request passes through the log unit with
// its 16 squaring stages, the curve stages, the 24 stages of the restoring
// divider and the final stages before its result appears.
// Reset is synchronous; busy is high only during reset. The receiver cannot
// stall, so the pipeline never holds.
module soft_knee_gain_computer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [skgc_pkg::SAMPLE_W-1:0] sample,
  input  logic [skgc_pkg::BAND_W-1:0]          band,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [skgc_pkg::IDX_W-1:0]           cfg_index,
  input  logic [skgc_pkg::BANK_W-1:0]          cfg_data,
  output logic                                 done,
  output logic signed [skgc_pkg::LVL_W-1:0]    input_level_db,
  output logic signed [skgc_pkg::LVL_W-1:0]    output_level_db
);

  logic [skgc_pkg::RATIO_W-1:0]         ratio;
  logic [skgc_pkg::KNEE_W-1:0]          knee_db;
  logic signed [skgc_pkg::MASTER_W-1:0] master_gain_db;
  logic [skgc_pkg::BANK_W-1:0]          band_thresholds;
  logic [skgc_pkg::BANK_W-1:0]          band_makeups;
  logic [skgc_pkg::ENA_W-1:0]           band_enables;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio           <= skgc_pkg::RATIO_RST;
      knee_db         <= '0;
      master_gain_db  <= '0;
      band_thresholds <= skgc_pkg::THRESH_RST;
      band_makeups    <= '0;
      band_enables    <= '0;
    end else if (cfg_valid) begin
      unique case (skgc_pkg::cfg_reg_t'(cfg_index))
        skgc_pkg::REG_RATIO:  ratio <= cfg_data[skgc_pkg::RATIO_W-1:0];
        skgc_pkg::REG_KNEE:   knee_db <= cfg_data[skgc_pkg::KNEE_W-1:0];
        skgc_pkg::REG_MASTER: master_gain_db <= $signed(cfg_data[skgc_pkg::MASTER_W-1:0]);
        skgc_pkg::REG_THRESH: band_thresholds <= cfg_data;
        skgc_pkg::REG_MAKEUP: band_makeups <= cfg_data;
        skgc_pkg::REG_ENABLE: band_enables <= cfg_data[skgc_pkg::ENA_W-1:0];
        default: ;
      endcase
    end
  end

  // Values derived from configuration; they settle long before a request
  // reaches the curve stages.
  logic [skgc_pkg::RATIO_W-1:0] r_eff;
  logic [skgc_pkg::RATIO_W-1:0] rm1;
  logic [skgc_pkg::W_W-1:0]     w_q;
  logic [skgc_pkg::DW-1:0]      den_q;

  always_ff @(posedge clk) begin
    r_eff <= (ratio < skgc_pkg::RATIO_MIN) ? skgc_pkg::RATIO_MIN : ratio;
    rm1   <= r_eff - skgc_pkg::RATIO_MIN;
    w_q   <= 23'({knee_db, 10'd0}) + 23'({knee_db, 9'd0}) + skgc_pkg::KNEE_BASE;
    den_q <= 37'({w_q, 1'b0}) * 37'(r_eff);
  end

  // Level in dB.
  skgc_pkg::log_tag_t              lg_in;
  skgc_pkg::log_tag_t              lg_out;
  logic [skgc_pkg::SAMPLE_W-1:0]   mag;
  logic signed [skgc_pkg::LVL_W-1:0] lg_lvl;

  assign lg_in.vld  = start && !busy;
  assign lg_in.band = band;
  assign mag = sample[15] ? (~sample + 16'd1) : sample;

  skgc_log u_log (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (lg_in),
    .mag     (mag),
    .tag_out (lg_out),
    .lvl     (lg_lvl)
  );

  // Curve stage 1: band select, knee region and knee offset.
  logic [skgc_pkg::BAND_W-1:0] bsel;
  logic [15:0]                 thr16;
  logic [15:0]                 mk16;
  logic                        ena;
  logic signed [25:0]          xg;
  logic signed [25:0]          thr;
  logic signed [26:0]          d;
  logic signed [27:0]          two_d;
  logic signed [27:0]          wv;
  logic signed [26:0]          t_full;
  skgc_pkg::cv_tag_t           c1_next;
  logic [31:0]                 nr_next;

  always_comb begin
    bsel  = (32'(lg_out.band) < skgc_pkg::BANDS) ? lg_out.band : '0;
    thr16 = band_thresholds[16*bsel +: 16];
    mk16  = band_makeups[16*bsel +: 16];
    ena   = band_enables[bsel] && (32'(lg_out.band) < skgc_pkg::BANDS);
    xg    = {lg_lvl[16], lg_lvl, 8'd0};
    thr   = {{2{thr16[15]}}, thr16, 8'd0};
    d     = {xg[25], xg} - {thr[25], thr};
    two_d = {d, 1'b0};
    wv    = {5'd0, w_q};
    t_full = d + $signed({5'd0, w_q[22:1]});
    nr_next = {d[23:0], 8'd0} + {20'd0, r_eff[12:1]};
    c1_next.vld    = lg_out.vld;
    c1_next.lvl    = lg_lvl;
    c1_next.bypass = !ena;
    if (two_d < -wv) begin
      c1_next.region = skgc_pkg::RG_BELOW;
      c1_next.base   = xg;
    end else if (two_d <= wv) begin
      c1_next.region = skgc_pkg::RG_KNEE;
      c1_next.base   = xg;
    end else begin
      c1_next.region = skgc_pkg::RG_ABOVE;
      c1_next.base   = thr;
    end
    c1_next.offs = $signed({2'b00, mk16}) + $signed({{4{master_gain_db[13]}}, master_gain_db});
  end

  skgc_pkg::cv_tag_t c1;
  skgc_pkg::cv_tag_t c2;
  skgc_pkg::cv_tag_t c3;
  logic [22:0]       t1;
  logic [31:0]       nr1;
  logic [31:0]       nr2;
  logic [45:0]       tt2;
  logic [skgc_pkg::NW-1:0] num3;
  logic [skgc_pkg::DW-1:0] den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld <= 1'b0;
      c2.vld <= 1'b0;
      c3.vld <= 1'b0;
    end else begin
      c1 <= c1_next;
      c2 <= c1;
      c3 <= c2;
    end
    t1  <= t_full[22:0];
    nr1 <= nr_next;
    tt2 <= 46'(t1) * 46'(t1);
    nr2 <= nr1;
    if (c2.region == skgc_pkg::RG_ABOVE) begin
      num3 <= 60'(nr2);
      den3 <= 37'(r_eff);
    end else begin
      num3 <= 60'(tt2) * 60'(rm1) + 60'(den_q[36:1]);
      den3 <= den_q;
    end
  end

  skgc_pkg::cv_tag_t       dv_tag;
  logic [skgc_pkg::QW-1:0] quo;

  skgc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (c3),
    .num     (num3),
    .den     (den3),
    .tag_out (dv_tag),
    .quo     (quo)
  );

  // Final stages: apply the curve result, gains, rounding and saturation.
  logic signed [29:0] qs;
  logic signed [29:0] base30;
  logic signed [29:0] y;
  logic signed [29:0] v_next;
  logic signed [17:0] bsum_next;

  always_comb begin
    qs     = $signed({6'd0, quo});
    base30 = {{4{dv_tag.base[25]}}, dv_tag.base};
    unique case (dv_tag.region)
      skgc_pkg::RG_KNEE:  y = base30 - qs;
      skgc_pkg::RG_ABOVE: y = base30 + qs;
      default:            y = base30;
    endcase
    v_next    = y + $signed({{4{dv_tag.offs[17]}}, dv_tag.offs, 8'd0});
    bsum_next = $signed({dv_tag.lvl[16], dv_tag.lvl})
              + $signed({{4{master_gain_db[13]}}, master_gain_db});
  end

  logic                              f1_vld;
  logic                              f1_bypass;
  logic signed [skgc_pkg::LVL_W-1:0] f1_lvl;
  logic signed [29:0]                f1_v;
  logic signed [17:0]                f1_bsum;
  logic signed [29:0]                rv;

  assign rv = (f1_v + 30'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      f1_vld <= dv_tag.vld;
      done   <= f1_vld;
    end
    f1_bypass <= dv_tag.bypass;
    f1_lvl    <= dv_tag.lvl;
    f1_v      <= v_next;
    f1_bsum   <= bsum_next;
    input_level_db  <= f1_lvl;
    output_level_db <= f1_bypass
                     ? skgc_pkg::sat_out({{12{f1_bsum[17]}}, f1_bsum})
                     : skgc_pkg::sat_out(rv);
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, skgc_pkg::LAT))
    else $error("result without a request at the pipeline latency");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (input_level_db <= 17'sd0 && input_level_db >= skgc_pkg::ZERO_DB))
    else $error("input level out of range");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (output_level_db <= skgc_pkg::OUT_MAX && output_level_db >= skgc_pkg::OUT_MIN))
    else $error("output level out of range");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && sample == 16'sd0, skgc_pkg::LAT))
      |-> input_level_db == skgc_pkg::ZERO_DB)
    else $error("zero sample did not give the floor level");
`endif

endmodule

[rtl/skgc_log.sv]
module skgc_log (
  input  logic                              clk,
  input  logic                              rst,
  input  skgc_pkg::log_tag_t                tag_in,
  input  logic [skgc_pkg::SAMPLE_W-1:0]     mag,
  output skgc_pkg::log_tag_t                tag_out,
  output logic signed [skgc_pkg::LVL_W-1:0] lvl
);

  localparam int S = skgc_pkg::SQ_STEPS;

  logic [3:0]  e_next;
  logic [30:0] x_next;

  skgc_pkg::log_tag_t ts [0:S];
  logic [30:0]        xs [0:S];
  logic [S-1:0]       fr [0:S];
  logic [3:0]         es [0:S];
  logic               zs [0:S];

  always_comb begin
    e_next = 4'd0;
    for (int i = 0; i < skgc_pkg::SAMPLE_W; i++) begin
      if (mag[i]) begin
        e_next = 4'(i);
      end
    end
    x_next = 31'({15'd0, mag} << (5'd30 - {1'b0, e_next}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ts[0].vld <= 1'b0;
    end else begin
      ts[0] <= tag_in;
    end
    xs[0] <= x_next;
    fr[0] <= '0;
    es[0] <= e_next;
    zs[0] <= (mag == '0);
  end

  // Each stage squares the mantissa and yields one fraction bit of log2.
  for (genvar k = 0; k < S; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] y;
    assign sq = 62'(xs[k]) * 62'(xs[k]);
    assign y  = sq[61:30];
    always_ff @(posedge clk) begin
      if (rst) begin
        ts[k+1].vld <= 1'b0;
      end else begin
        ts[k+1] <= ts[k];
      end
      xs[k+1] <= y[31] ? y[31:1] : y[30:0];
      fr[k+1] <= {fr[k][S-2:0], y[31]};
      es[k+1] <= es[k];
      zs[k+1] <= zs[k];
    end
  end

  logic [19:0]        down;
  logic [38:0]        prod;
  logic [38:0]        prod_rnd;
  logic               zp;
  skgc_pkg::log_tag_t tp;

  assign down     = {4'd15 - es[S], 16'd0} - {4'd0, fr[S]};
  assign prod_rnd = prod + 39'd8388608;

  always_ff @(posedge clk) begin
    if (rst) begin
      tp.vld      <= 1'b0;
      tag_out.vld <= 1'b0;
    end else begin
      tp      <= ts[S];
      tag_out <= tp;
    end
    prod <= 39'(down) * 39'(skgc_pkg::DB_PER_OCT);
    zp   <= zs[S];
    lvl  <= zp ? skgc_pkg::ZERO_DB : -$signed({2'b00, prod_rnd[38:24]});
  end

endmodule

[rtl/skgc_div.sv]
module skgc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  skgc_pkg::cv_tag_t          tag_in,
  input  logic [skgc_pkg::NW-1:0]    num,
  input  logic [skgc_pkg::DW-1:0]    den,
  output skgc_pkg::cv_tag_t          tag_out,
  output logic [skgc_pkg::QW-1:0]    quo
);

  localparam int QW = skgc_pkg::QW;
  localparam int NW = skgc_pkg::NW;
  localparam int DW = skgc_pkg::DW;

  skgc_pkg::cv_tag_t tg  [0:QW];
  logic [NW-1:0]     rem [0:QW];
  logic [DW-1:0]     dv  [0:QW];
  logic [QW-1:0]     qq  [0:QW];

  assign tg[0]  = tag_in;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign qq[0]  = '0;

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int I = QW - 1 - k;
    logic [NW:0] sh;
    logic [NW:0] rx;
    logic        ge;
    assign sh = {{(NW + 1 - DW){1'b0}}, dv[k]} << I;
    assign rx = {1'b0, rem[k]};
    assign ge = (rx >= sh);
    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k+1].vld <= 1'b0;
      end else begin
        tg[k+1] <= tg[k];
      end
      rem[k+1] <= ge ? NW'(rx - sh) : rem[k];
      dv[k+1]  <= dv[k];
      qq[k+1]  <= {qq[k][QW-2:0], ge};
    end
  end

  assign tag_out = tg[QW];
  assign quo     = qq[QW];

endmodule
